/* hdl/dispersion_wavelength_calibrator_macros.svh */
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef DISPERSION_WAVELENGTH_CALIBRATOR_MACROS_SVH
`define DISPERSION_WAVELENGTH_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define DWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dwc_pkg.sv */
package dwc_pkg;

  localparam int VAL_W     = 64;
  localparam int POS_W     = 32;
  localparam int WID_W     = 63;
  localparam int COEF_FRAC = 40;
  localparam int NUM_LANES = 3;
  localparam int ORDER_W   = 3;
  localparam int IDX_W     = 3;
  localparam int MUL_LAT   = 4;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 3;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_PRISM_MODE = 3'd0,
    REG_POLY_ORDER = 3'd1,
    REG_COEFF_0    = 3'd2,
    REG_COEFF_1    = 3'd3,
    REG_COEFF_2    = 3'd4,
    REG_COEFF_3    = 3'd5,
    REG_COEFF_4    = 3'd6,
    REG_COEFF_5    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_POLE = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic sat;
    val_t val;
  } sval_t;

  typedef struct packed {
    val_t acc;
    val_t opnd;
    logic sat;
  } lane_t;

  typedef struct packed {
    logic                        pole;
    lane_t [NUM_LANES-1:0]       lane;
  } item_t;

  typedef struct packed {
    logic               prism;
    logic [ORDER_W-1:0] order;
  } mode_t;

  function automatic sval_t sat_add(val_t a, val_t b);
    logic [VAL_W:0] s;
    sval_t r;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    r.sat = s[VAL_W] ^ s[VAL_W-1];
    r.val = r.sat ? (s[VAL_W] ? VAL_MIN : VAL_MAX) : val_t'(s[VAL_W-1:0]);
    return r;
  endfunction

  function automatic sval_t sat_sub(val_t a, val_t b);
    logic [VAL_W:0] s;
    sval_t r;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    r.sat = s[VAL_W] ^ s[VAL_W-1];
    r.val = r.sat ? (s[VAL_W] ? VAL_MIN : VAL_MAX) : val_t'(s[VAL_W-1:0]);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag(val_t v);
    logic [VAL_W-1:0] u;
    u = v;
    return v[VAL_W-1] ? (~u + 1'b1) : u;
  endfunction

  // magnitude with an overflow bit on top, back to a signed value
  function automatic sval_t from_mag(logic neg, logic [VAL_W:0] m);
    sval_t r;
    if (!neg) begin
      r.sat = m[VAL_W] | m[VAL_W-1];
      r.val = r.sat ? VAL_MAX : val_t'(m[VAL_W-1:0]);
    end else begin
      r.sat = m[VAL_W] | (m[VAL_W-1] & (|m[VAL_W-2:0]));
      r.val = r.sat ? VAL_MIN : val_t'(~m[VAL_W-1:0] + 1'b1);
    end
    return r;
  endfunction

endpackage

/* hdl/dwc_mul.sv */
module dwc_mul #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           adv,
  input  dwc_pkg::val_t  acc,
  input  dwc_pkg::val_t  x,
  output dwc_pkg::sval_t res
);

  localparam int VW = dwc_pkg::VAL_W;
  localparam int HW = VW / 2;
  localparam int PW = VW + HW;
  localparam logic [PW-1:0] HALF = PW'(1) << (POS_FRAC_BITS - 1);

  logic [VW-1:0]   am_r;
  logic [HW-1:0]   xm_r;
  logic            neg1_r, neg2_r, neg3_r;
  logic [VW-1:0]   plo_r, phi_r;
  logic [VW:0]     m_r;
  dwc_pkg::sval_t  res_r;
  logic [PW-1:0]   p;
  logic [VW-1:0]   xm;

  always_comb begin
    xm = dwc_pkg::mag(x);
    p  = {{HW{1'b0}}, plo_r} + {phi_r, {HW{1'b0}}} + HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      am_r   <= dwc_pkg::mag(acc);
      xm_r   <= xm[HW-1:0];
      neg1_r <= acc[VW-1] ^ x[VW-1];
      plo_r  <= am_r[HW-1:0] * xm_r;
      phi_r  <= am_r[VW-1:HW] * xm_r;
      neg2_r <= neg1_r;
      m_r    <= {|p[PW-1:VW+POS_FRAC_BITS], p[VW+POS_FRAC_BITS-1:POS_FRAC_BITS]};
      neg3_r <= neg2_r;
      res_r  <= dwc_pkg::from_mag(neg3_r, m_r);
    end
  end

  assign res = res_r;

endmodule

/* hdl/dwc_div.sv */
module dwc_div (
  input  logic           clk,
  input  logic           adv,
  input  dwc_pkg::val_t  num,
  input  dwc_pkg::val_t  den,
  output dwc_pkg::sval_t res
);

  localparam int VW = dwc_pkg::VAL_W;
  localparam int CF = dwc_pkg::COEF_FRAC;
  localparam int NS = dwc_pkg::DIV_STEPS;

  logic [VW-1:0]  rem_r [0:NS];
  logic [VW-1:0]  w_r   [0:NS];
  logic [VW-1:0]  dv_r  [0:NS];
  logic [NS:0]    neg_r;
  logic [NS:0]    ovf_r;
  logic [VW:0]    qr_r;
  logic           qneg_r, qovf_r;
  dwc_pkg::sval_t res_r;
  logic [VW-1:0]  am, dm, rem0;
  logic           rnd;

  always_comb begin
    am   = dwc_pkg::mag(num);
    dm   = dwc_pkg::mag(den);
    rem0 = {{(VW-CF){1'b0}}, am[VW-1:VW-CF]};
    rnd  = {rem_r[NS], 1'b0} >= {1'b0, dv_r[NS]};
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= rem0;
      w_r[0]   <= {am[VW-CF-1:0], {CF{1'b0}}};
      dv_r[0]  <= dm;
      neg_r[0] <= num[VW-1] ^ den[VW-1];
      ovf_r[0] <= rem0 >= dm;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_it
    logic [VW:0] t, df;
    logic        ge;

    always_comb begin
      t  = {rem_r[k], w_r[k][VW-1]};
      df = t - {1'b0, dv_r[k]};
      ge = t >= {1'b0, dv_r[k]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? df[VW-1:0] : t[VW-1:0];
        w_r[k+1]   <= {w_r[k][VW-2:0], ge};
        dv_r[k+1]  <= dv_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qr_r   <= {1'b0, w_r[NS]} + {{VW{1'b0}}, rnd};
      qneg_r <= neg_r[NS];
      qovf_r <= ovf_r[NS];
      res_r  <= dwc_pkg::from_mag(qneg_r, {qovf_r | qr_r[VW], qr_r[VW-1:0]});
    end
  end

  assign res = res_r;

endmodule

/* hdl/dwc_step.sv */
module dwc_step #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           prism,
  input  logic           step_on,
  input  dwc_pkg::val_t  coef,
  input  logic           in_vld,
  input  dwc_pkg::item_t in_item,
  output logic           out_vld,
  output dwc_pkg::item_t out_item
);

  localparam int ML = dwc_pkg::MUL_LAT;
  localparam int DL = dwc_pkg::DIV_LAT;
  localparam int NL = dwc_pkg::NUM_LANES;

  logic [ML-1:0]  gv_r, gv_nxt;
  logic [DL-1:0]  pv_r, pv_nxt;
  dwc_pkg::item_t gi_r [ML];
  dwc_pkg::item_t pi_r [DL];
  logic           out_vld_r, out_vld_nxt;
  dwc_pkg::item_t out_item_r, out_item_nxt;
  dwc_pkg::sval_t mres [NL];
  dwc_pkg::sval_t dres [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    dwc_mul #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_mul (
      .clk (clk),
      .adv (adv),
      .acc (in_item.lane[l].acc),
      .x   (in_item.lane[l].opnd),
      .res (mres[l])
    );
    dwc_div u_div (
      .clk (clk),
      .adv (adv),
      .num (in_item.lane[l].acc),
      .den (in_item.lane[l].opnd),
      .res (dres[l])
    );
  end

  always_comb begin
    gv_nxt = {gv_r[ML-2:0], in_vld & ~prism};
    pv_nxt = {pv_r[DL-2:0], in_vld & prism};
  end

  always_comb begin
    dwc_pkg::sval_t r, s;
    out_vld_nxt  = gv_r[ML-1] | pv_r[DL-1];
    out_item_nxt = prism ? pi_r[DL-1] : gi_r[ML-1];
    for (int l = 0; l < NL; l++) begin
      r = prism ? dres[l] : mres[l];
      s = dwc_pkg::sat_add(r.val, coef);
      if (step_on) begin
        out_item_nxt.lane[l].acc = s.val;
        out_item_nxt.lane[l].sat = out_item_nxt.lane[l].sat | r.sat | s.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r      <= '0;
      pv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      gv_r      <= gv_nxt;
      pv_r      <= pv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gi_r[0]    <= in_item;
      pi_r[0]    <= in_item;
      for (int k = 1; k < ML; k++) gi_r[k] <= gi_r[k-1];
      for (int k = 1; k < DL; k++) pi_r[k] <= pi_r[k-1];
      out_item_r <= out_item_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

/* hdl/dwc_front.sv */
module dwc_front #(
  parameter int NUM_COEFFS    = 6,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  dwc_pkg::mode_t                    mode,
  input  dwc_pkg::val_t                     coeff [NUM_COEFFS],
  input  logic                              in_vld,
  input  logic signed [dwc_pkg::POS_W-1:0]  in_pos,
  output logic                              out_vld,
  output dwc_pkg::item_t                    out_item
);

  localparam int VW = dwc_pkg::VAL_W;
  localparam int NL = dwc_pkg::NUM_LANES;
  localparam int SH = dwc_pkg::COEF_FRAC - POS_FRAC_BITS;
  localparam int CW = $clog2(NUM_COEFFS);
  localparam dwc_pkg::val_t HALF = dwc_pkg::val_t'(1) << (POS_FRAC_BITS - 1);

  logic [2:0]     vld_r, vld_nxt;
  dwc_pkg::val_t  x0_r [NL];
  dwc_pkg::val_t  x1_r [NL];
  dwc_pkg::val_t  xq_r [NL];
  logic [NL-1:0]  xsat_r;
  dwc_pkg::item_t item_r, item_nxt;
  dwc_pkg::val_t  xin;
  dwc_pkg::val_t  xq  [NL];
  logic [NL-1:0]  xsat;

  always_comb begin
    xin = {{(VW-dwc_pkg::POS_W){in_pos[dwc_pkg::POS_W-1]}}, in_pos};
  end

  // position scaled up to the coefficient format, clamped
  always_comb begin
    logic [VW+SH-1:0] xw;
    for (int l = 0; l < NL; l++) begin
      xw = {{SH{x0_r[l][VW-1]}}, x0_r[l]} << SH;
      xsat[l] = !((&xw[VW+SH-1:VW-1]) || !(|xw[VW+SH-1:VW-1]));
      xq[l] = xsat[l] ? (xw[VW+SH-1] ? dwc_pkg::VAL_MIN : dwc_pkg::VAL_MAX)
                      : dwc_pkg::val_t'(xw[VW-1:0]);
    end
  end

  always_comb begin
    dwc_pkg::sval_t d;
    item_nxt.pole = 1'b0;
    for (int l = 0; l < NL; l++) begin
      d = dwc_pkg::sat_sub(xq_r[l], coeff[0]);
      item_nxt.lane[l].acc  = coeff[mode.order[CW-1:0]];
      item_nxt.lane[l].opnd = mode.prism ? d.val : x1_r[l];
      item_nxt.lane[l].sat  = mode.prism & (xsat_r[l] | d.sat);
      item_nxt.pole         = item_nxt.pole | (mode.prism & (d.val == '0));
    end
  end

  assign vld_nxt = {vld_r[1:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r[0] <= xin;
      x0_r[1] <= xin - HALF;
      x0_r[2] <= xin + HALF;
      x1_r    <= x0_r;
      xq_r    <= xq;
      xsat_r  <= xsat;
      item_r  <= item_nxt;
    end
  end

  assign out_vld  = vld_r[2];
  assign out_item = item_r;

endmodule

/* hdl/dispersion_wavelength_calibrator.sv */
// Polynomial wavelength solution for one trace position per beat. Each position x gives
// the wavelength f(x) and the pixel width |f(x+1/2) - f(x-1/2)|; the three points run as
// lanes through one Horner stage per coefficient below the leading one. Grism mode
// (prism_mode 0) uses a power polynomial, prism mode a polynomial in 1/(x - c0), where
// x == c0 returns status 1 with zero values; any saturation returns status 2. A new beat
// is taken every clock while the output is drained. Prism mode runs through the 64-stage
// restoring divider in each Horner stage. The user must write registers only while no
// beat is in flight; the block itself does not enforce this.
`include "dispersion_wavelength_calibrator_macros.svh"

module dispersion_wavelength_calibrator #(
  parameter int NUM_COEFFS    = 6,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dwc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dwc_pkg::VAL_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [dwc_pkg::POS_W-1:0]   in_trace_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dwc_pkg::VAL_W-1:0]   out_wavelength,
  output logic [dwc_pkg::WID_W-1:0]          out_wavelength_width,
  output logic [1:0]                         out_result_status
);

  localparam int OW = dwc_pkg::ORDER_W;
  localparam int NS = NUM_COEFFS - 1;

  logic               prism_r;
  logic [OW-1:0]      order_r;
  dwc_pkg::val_t      coeff_r [NUM_COEFFS];
  logic [OW-1:0]      ord;
  dwc_pkg::mode_t     mode;
  logic               adv;
  logic [NS:0]        stg_vld;
  dwc_pkg::item_t     stg_item [NS+1];
  logic [NS-1:0]      step_on;

  logic               bv_r, bv_nxt;
  dwc_pkg::val_t      lam_r, lam_nxt;
  dwc_pkg::val_t      diff_r, diff_nxt;
  logic               bsat_r, bsat_nxt;
  logic               bpole_r;
  logic               out_valid_r, out_valid_nxt;
  dwc_pkg::val_t      out_wl_r, out_wl_nxt;
  logic [dwc_pkg::WID_W-1:0] out_wid_r, out_wid_nxt;
  dwc_pkg::status_t   out_st_r, out_st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prism_r <= 1'b0;
      order_r <= OW'(1);
      for (int k = 0; k < NUM_COEFFS; k++) coeff_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == dwc_pkg::REG_PRISM_MODE) prism_r <= cfg_wdata[0];
      if (cfg_index == dwc_pkg::REG_POLY_ORDER) order_r <= cfg_wdata[OW-1:0];
      for (int k = 0; k < NUM_COEFFS; k++) begin
        if (cfg_index == dwc_pkg::IDX_W'(dwc_pkg::REG_COEFF_0 + k)) coeff_r[k] <= cfg_wdata;
      end
    end
  end

  assign ord        = (order_r > OW'(NUM_COEFFS - 1)) ? OW'(NUM_COEFFS - 1) : order_r;
  assign mode.prism = prism_r;
  assign mode.order = ord;
  assign adv        = !out_valid_r || out_ready;
  assign in_ready   = adv;

  dwc_front #(.NUM_COEFFS(NUM_COEFFS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .mode     (mode),
    .coeff    (coeff_r),
    .in_vld   (in_valid),
    .in_pos   (in_trace_position),
    .out_vld  (stg_vld[0]),
    .out_item (stg_item[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int CI = NUM_COEFFS - 2 - k;

    assign step_on[k] = (ord > OW'(CI)) && (!prism_r || (CI != 0));

    dwc_step #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .prism    (prism_r),
      .step_on  (step_on[k]),
      .coef     (coeff_r[CI]),
      .in_vld   (stg_vld[k]),
      .in_item  (stg_item[k]),
      .out_vld  (stg_vld[k+1]),
      .out_item (stg_item[k+1])
    );
  end

  always_comb begin
    logic           zero;
    dwc_pkg::val_t  lv [dwc_pkg::NUM_LANES];
    dwc_pkg::sval_t d;
    zero     = prism_r && (ord == '0);
    bsat_nxt = 1'b0;
    for (int l = 0; l < dwc_pkg::NUM_LANES; l++) begin
      lv[l]    = zero ? '0 : stg_item[NS].lane[l].acc;
      bsat_nxt = bsat_nxt | stg_item[NS].lane[l].sat;
    end
    d        = dwc_pkg::sat_sub(lv[2], lv[1]);
    bv_nxt   = stg_vld[NS];
    lam_nxt  = lv[0];
    diff_nxt = d.val;
    bsat_nxt = bsat_nxt | d.sat;
  end

  always_comb begin
    logic [dwc_pkg::VAL_W-1:0] dm;
    logic                      dmin;
    dm            = dwc_pkg::mag(diff_r);
    dmin          = diff_r == dwc_pkg::VAL_MIN;
    out_valid_nxt = bv_r;
    if (bpole_r) begin
      out_wl_nxt  = '0;
      out_wid_nxt = '0;
      out_st_nxt  = dwc_pkg::ST_POLE;
    end else begin
      out_wl_nxt  = lam_r;
      out_wid_nxt = dmin ? dwc_pkg::VAL_MAX[dwc_pkg::WID_W-1:0] : dm[dwc_pkg::WID_W-1:0];
      out_st_nxt  = (bsat_r || dmin) ? dwc_pkg::ST_SAT : dwc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      bv_r        <= bv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lam_r     <= lam_nxt;
      diff_r    <= diff_nxt;
      bsat_r    <= bsat_nxt;
      bpole_r   <= stg_item[NS].pole;
      out_wl_r  <= out_wl_nxt;
      out_wid_r <= out_wid_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_wavelength       = out_wl_r;
  assign out_wavelength_width = out_wid_r;
  assign out_result_status    = out_st_r;

  `DWC_ASSERT_NOW(a_pole_zero, out_valid && out_result_status == dwc_pkg::ST_POLE, out_wavelength == '0 && out_wavelength_width == '0, "pole beat with nonzero values")
  `DWC_ASSERT_NOW(a_pole_prism, out_valid && out_result_status == dwc_pkg::ST_POLE, prism_r, "pole reported in grism mode")
  `DWC_ASSERT_NOW(a_stall_src, !in_ready, out_valid && !out_ready, "input held off without output backpressure")
  `DWC_ASSERT_NEXT(a_out_fill, adv && bv_r, out_valid, "beat lost before output register")

endmodule
